// ----- src/angle_sector_decomposition_unit_defines.svh -----
// Assertion macros for the angle sector decomposition unit
`ifndef ANGLE_SECTOR_DECOMPOSITION_UNIT_DEFINES_SVH
`define ANGLE_SECTOR_DECOMPOSITION_UNIT_DEFINES_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled during reset
`define ASDU_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("asdu: implication check failed");
// Delayed implication; the delay is the n argument
`define ASDU_ASSERT_DELAY(lbl, clk, rst, ante, n, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> ##n (cons)) \
    else $error("asdu: delayed check failed");
`else
`define ASDU_ASSERT_IMPLY(lbl, clk, rst, ante, cons)
`define ASDU_ASSERT_DELAY(lbl, clk, rst, ante, n, cons)
`endif
`endif

// ----- src/asdu_pkg.sv -----
// Shared types, constants and coefficient tables for the angle sector unit
`timescale 1ns / 1ps
package asdu_pkg;

  localparam int COORD_WIDTH_DEF = 32;
  localparam int CFG_IDX_W       = 1;
  localparam int CFG_DATA_W      = 9;
  localparam int LEVEL_W         = 4;
  localparam int PAL_W           = 9;
  localparam int BITS_W          = 8;
  localparam int COLOUR_W        = 9;
  localparam int COEF_W          = 17;
  localparam int NUM_CELLS       = 5;
  localparam int ROT_CELLS       = 4;
  localparam int LATENCY         = 2 + 2 * NUM_CELLS;

  localparam logic [LEVEL_W-1:0] LEVEL_MIN   = 4'd1;
  localparam logic [LEVEL_W-1:0] LEVEL_MAX   = 4'd8;
  localparam logic [LEVEL_W-1:0] LEVEL_SWAP  = 4'd3;
  localparam logic [LEVEL_W-1:0] LEVEL_RESET = 4'd8;
  localparam logic [PAL_W-1:0]   PAL_RESET   = 9'd256;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SECTOR_LEVEL    = 1'b0,
    CFG_PALETTE_COLOURS = 1'b1
  } cfg_reg_t;

  // Control word that travels down the cell chain beside the coordinates
  typedef struct packed {
    logic                 valid;
    logic [BITS_W-1:0]    bits;
    logic [LEVEL_W-1:0]   level;
    logic                 plus_one;
  } ctl_t;

  // Coordinate bits actually used: 16 to 32
  function automatic int coord_eff(input int cw);
    int w;
    begin
      w = cw;
      if (w > 32) w = 32;
      if (w < 16) w = 16;
      return w;
    end
  endfunction

  // Q1.16 tangents of the half-wedge angles, one per cell
  function automatic logic [COEF_W-1:0] cell_tan(input int k);
    begin
      case (k)
        0:       return 17'd27146;
        1:       return 17'd13036;
        2:       return 17'd6455;
        3:       return 17'd3220;
        default: return 17'd1609;
      endcase
    end
  endfunction

  function automatic logic [COEF_W-1:0] cell_cos(input int k);
    begin
      case (k)
        0:       return 17'd46341;
        1:       return 17'd60547;
        2:       return 17'd64277;
        default: return 17'd65220;
      endcase
    end
  endfunction

  function automatic logic [COEF_W-1:0] cell_sin(input int k);
    begin
      case (k)
        0:       return 17'd46341;
        1:       return 17'd25080;
        2:       return 17'd12785;
        default: return 17'd6424;
      endcase
    end
  endfunction

endpackage

// ----- src/angle_sector_decomposition_unit.sv -----
// Top level: binary decomposition colouring by angle sector
//
//  channel  | ports                                  | handshake
//  ---------+----------------------------------------+------------------------
//  item in  | start, busy, z_re, z_im                | start & !busy
//  result   | done, colour_index                     | done, one cycle, no stall
//  config   | cfg_write, cfg_index, cfg_data         | cfg_write
//
// One item per cycle; after its transfer each result passes through
// one entry stage, two stages per fold cell (multiply, then compare and
// round) over five cells, and one output stage. The multiplier stage of each
// cell sets the clock path. busy is never raised. Synchronous reset clears
// the valid marks in the chain and loads the registers with level 8 and
// palette 256.
`timescale 1ns / 1ps
`include "angle_sector_decomposition_unit_defines.svh"
module angle_sector_decomposition_unit #(
  parameter int COORD_WIDTH = asdu_pkg::COORD_WIDTH_DEF
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [31:0]                  z_re,
  input  logic signed [31:0]                  z_im,
  output logic                                done,
  output logic [asdu_pkg::COLOUR_W-1:0]       colour_index,
  input  logic                                cfg_write,
  input  logic [asdu_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [asdu_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import asdu_pkg::*;

  localparam int IW  = coord_eff(COORD_WIDTH);
  localparam int XW  = IW + 3;
  localparam int LAT = LATENCY;

  logic [LEVEL_W-1:0] sector_level;
  logic [PAL_W-1:0]   palette_colours;
  logic [LEVEL_W-1:0] level_eff;
  logic               plus_one;
  logic               accept;

  ctl_t                 chain_ctl [0:NUM_CELLS];
  logic signed [XW-1:0] chain_x   [0:NUM_CELLS];
  logic signed [XW-1:0] chain_y   [0:NUM_CELLS];

  always_ff @(posedge clk) begin
    if (rst) begin
      sector_level    <= LEVEL_RESET;
      palette_colours <= PAL_RESET;
    end else if (cfg_write) begin
      unique case (cfg_reg_t'(cfg_index))
        CFG_SECTOR_LEVEL:    sector_level    <= cfg_data[LEVEL_W-1:0];
        CFG_PALETTE_COLOURS: palette_colours <= cfg_data[PAL_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    level_eff = sector_level;
    if (sector_level < LEVEL_MIN) level_eff = LEVEL_MIN;
    if (sector_level > LEVEL_MAX) level_eff = LEVEL_MAX;
    plus_one = palette_colours > (9'd1 << level_eff);
  end

  assign busy   = 1'b0;
  assign accept = start & ~busy;

  asdu_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk      (clk),
    .rst      (rst),
    .accept   (accept),
    .z_re     (z_re),
    .z_im     (z_im),
    .level    (level_eff),
    .plus_one (plus_one),
    .ctl_out  (chain_ctl[0]),
    .x_out    (chain_x[0]),
    .y_out    (chain_y[0])
  );

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    asdu_cell #(.COORD_WIDTH(COORD_WIDTH), .CELL_IDX(k)) u_cell (
      .clk     (clk),
      .rst     (rst),
      .ctl_in  (chain_ctl[k]),
      .x_in    (chain_x[k]),
      .y_in    (chain_y[k]),
      .ctl_out (chain_ctl[k+1]),
      .x_out   (chain_x[k+1]),
      .y_out   (chain_y[k+1])
    );
  end

  asdu_colour u_colour (
    .clk          (clk),
    .rst          (rst),
    .ctl_in       (chain_ctl[NUM_CELLS]),
    .done         (done),
    .colour_index (colour_index)
  );

  `ASDU_ASSERT_DELAY(a_result_follows, clk, rst, accept, LAT, done)
  `ASDU_ASSERT_IMPLY(a_result_has_item, clk, rst, done, $past(accept, LAT))
  `ASDU_ASSERT_IMPLY(a_level_one_range, clk, rst, done && (level_eff == LEVEL_MIN), colour_index < 9'd3)

endmodule

// ----- src/asdu_front.sv -----
// Entry stage: coordinate extraction, quadrant bits and 45 degree swap
`timescale 1ns / 1ps
module asdu_front #(
  parameter int COORD_WIDTH = asdu_pkg::COORD_WIDTH_DEF
) (
  input  logic                                            clk,
  input  logic                                            rst,
  input  logic                                            accept,
  input  logic signed [31:0]                              z_re,
  input  logic signed [31:0]                              z_im,
  input  logic [asdu_pkg::LEVEL_W-1:0]                    level,
  input  logic                                            plus_one,
  output asdu_pkg::ctl_t                                  ctl_out,
  output logic signed [asdu_pkg::coord_eff(COORD_WIDTH)+2:0] x_out,
  output logic signed [asdu_pkg::coord_eff(COORD_WIDTH)+2:0] y_out
);
  import asdu_pkg::*;

  localparam int IW = coord_eff(COORD_WIDTH);
  localparam int XW = IW + 3;

  logic signed [XW-1:0] xs, ys, ax, ay;
  logic [1:0]           quad;
  logic                 swap;
  ctl_t                 ctl_next;

  always_comb begin
    xs   = XW'($signed(z_re[IW-1:0]));
    ys   = XW'($signed(z_im[IW-1:0]));
    quad = {ys[XW-1], xs[XW-1]};
    ax   = xs[XW-1] ? -xs : xs;
    ay   = ys[XW-1] ? -ys : ys;
    swap = (level >= LEVEL_SWAP) && (ax < ay);
    ctl_next.valid    = accept;
    ctl_next.level    = level;
    ctl_next.plus_one = plus_one;
    ctl_next.bits     = (level >= LEVEL_SWAP) ? {5'b0, quad, swap} : {6'b0, quad};
  end

  always_ff @(posedge clk) begin
    if (rst) ctl_out <= '0;
    else ctl_out <= ctl_next;
    x_out   <= swap ? ay : ax;
    y_out   <= swap ? ax : ay;
  end

endmodule

// ----- src/asdu_cell.sv -----
// One fold cell: tangent compare and, in the first four cells, reflection about the wedge bisector
`timescale 1ns / 1ps
module asdu_cell #(
  parameter int COORD_WIDTH = asdu_pkg::COORD_WIDTH_DEF,
  parameter int CELL_IDX    = 0
) (
  input  logic                                               clk,
  input  logic                                               rst,
  input  asdu_pkg::ctl_t                                     ctl_in,
  input  logic signed [asdu_pkg::coord_eff(COORD_WIDTH)+2:0] x_in,
  input  logic signed [asdu_pkg::coord_eff(COORD_WIDTH)+2:0] y_in,
  output asdu_pkg::ctl_t                                     ctl_out,
  output logic signed [asdu_pkg::coord_eff(COORD_WIDTH)+2:0] x_out,
  output logic signed [asdu_pkg::coord_eff(COORD_WIDTH)+2:0] y_out
);
  import asdu_pkg::*;

  localparam int IW  = coord_eff(COORD_WIDTH);
  localparam int XW  = IW + 3;
  localparam int PW  = XW + COEF_W + 1;
  localparam bit ROT = (CELL_IDX < ROT_CELLS);
  localparam logic [LEVEL_W-1:0] LEVEL_ON = LEVEL_W'(CELL_IDX + 4);
  localparam logic signed [COEF_W:0] TAN_S = $signed({1'b0, cell_tan(CELL_IDX)});
  localparam logic signed [COEF_W:0] COS_S = $signed({1'b0, cell_cos(CELL_IDX)});
  localparam logic signed [COEF_W:0] SIN_S = $signed({1'b0, cell_sin(CELL_IDX)});
  localparam logic signed [PW:0]     HALF  = (PW+1)'(32768);

  // product stage
  ctl_t                 ctl_a;
  logic signed [XW-1:0] x_a, y_a;
  logic signed [PW-1:0] p_tan, p_xc, p_ys, p_xs, p_yc;

  // fold stage
  logic signed [PW-1:0] y_shift;
  logic signed [PW:0]   sum_x, sum_y;
  logic                 hit, active;
  ctl_t                 ctl_next;
  logic signed [XW-1:0] x_next, y_next;

  always_ff @(posedge clk) begin
    if (rst) ctl_a <= '0;
    else ctl_a <= ctl_in;
    x_a   <= x_in;
    y_a   <= y_in;
    p_tan <= PW'(x_in) * PW'(TAN_S);
    p_xc  <= PW'(x_in) * PW'(COS_S);
    p_ys  <= PW'(y_in) * PW'(SIN_S);
    p_xs  <= PW'(x_in) * PW'(SIN_S);
    p_yc  <= PW'(y_in) * PW'(COS_S);
  end

  always_comb begin
    y_shift = PW'(y_a) <<< 16;
    hit     = p_tan < y_shift;
    active  = ctl_a.level >= LEVEL_ON;
    // round half up: floor((s + 2^15) / 2^16)
    sum_x   = (PW+1)'(p_xc) + (PW+1)'(p_ys) + HALF;
    sum_y   = (PW+1)'(p_xs) - (PW+1)'(p_yc) + HALF;
    ctl_next = ctl_a;
    x_next   = x_a;
    y_next   = y_a;
    if (active) begin
      ctl_next.bits = {ctl_a.bits[BITS_W-2:0], hit};
      if (ROT && hit) begin
        x_next = sum_x[XW+15:16];
        y_next = sum_y[XW+15:16];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) ctl_out <= '0;
    else ctl_out <= ctl_next;
    x_out   <= x_next;
    y_out   <= y_next;
  end

endmodule

// ----- src/asdu_colour.sv -----
// Output stage: Gray-style fold of the sector bits into a colour index
`timescale 1ns / 1ps
module asdu_colour (
  input  logic                            clk,
  input  logic                            rst,
  input  asdu_pkg::ctl_t                  ctl_in,
  output logic                            done,
  output logic [asdu_pkg::COLOUR_W-1:0]   colour_index
);
  import asdu_pkg::*;

  logic [BITS_W-1:0]   fold;
  logic [COLOUR_W-1:0] colour_next;

  always_comb begin
    fold = '0;
    // a set bit at level i mirrors the colour within 2^i entries
    for (int i = 1; i <= BITS_W; i++) begin
      if (ctl_in.bits[i-1]) fold = fold ^ BITS_W'((9'd1 << i) - 9'd1);
    end
    if (ctl_in.level == LEVEL_MIN) fold = {{(BITS_W-1){1'b0}}, fold[0]};
    colour_next = {1'b0, fold} + {{(COLOUR_W-1){1'b0}}, ctl_in.plus_one};
  end

  always_ff @(posedge clk) begin
    colour_index <= colour_next;
    if (rst) done <= 1'b0;
    else done <= ctl_in.valid;
  end

endmodule
